// ===== src/fesm_pkg.sv =====
// Shared types and constants for the fork extent segment mapper.
// Used by every module of the block; depends on nothing else.
package fesm_pkg;

  localparam int unsigned MAX_RUNS_DEF = 64;
  localparam int unsigned SECTOR_SHIFT = 9;
  localparam int unsigned SRC_W        = 50;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_XLATE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BEYOND    = 2'd1,
    ST_UNCOVERED = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_BLOCK_BYTES  = 2'd0,
    CFG_START_SECTOR = 2'd1,
    CFG_IMAGE_BYTES  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] run_start;
    logic [15:0] run_count;
    logic [31:0] fork_offset;
    logic [31:0] range_length;
  } req_t;

  typedef struct packed {
    logic [47:0] image_address;
    logic [31:0] segment_bytes;
    logic [31:0] dest_offset;
    logic [1:0]  status;
    logic        last;
  } res_t;

  // One walked run leaving the segment pipeline.
  typedef struct packed {
    logic             valid;
    logic             eot;
    logic             tok_ok;
    logic             ovl;
    logic             done;
    logic [SRC_W-1:0] src;
    logic [31:0]      n;
    logic [31:0]      dst;
  } seg_ev_t;

  typedef struct packed {
    logic kill;
    logic finish;
  } walk_ctl_t;

endpackage

// ===== src/fesm_run_mem.sv =====
// Run table memory: one write port, one read port with registered data.
// Each word holds a run's start block (upper half) and block count (lower half).
module fesm_run_mem #(
  parameter int unsigned MaxRuns = fesm_pkg::MAX_RUNS_DEF
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(MaxRuns)-1:0] waddr_i,
  input  logic [31:0]                wdata_i,
  input  logic [$clog2(MaxRuns)-1:0] raddr_i,
  output logic [31:0]                rdata_o
);

  logic [31:0] mem_q [MaxRuns];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fesm_seg_pipe.sv =====
// Segment pipeline: run bytes and block address multiply, running byte position,
// then segment length and image address. Depends on fesm_pkg.
module fesm_seg_pipe #(
  parameter int unsigned MaxRuns = fesm_pkg::MAX_RUNS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  logic                rd_v_i,
  input  logic                rd_eot_i,
  input  logic [31:0]         rd_data_i,
  input  logic [31:0]         block_bytes_i,
  input  logic [15:0]         start_sector_i,
  input  logic [31:0]         fork_offset_i,
  input  logic [31:0]         range_length_i,
  input  fesm_pkg::walk_ctl_t ctl_i,
  output logic                stop_o,
  output fesm_pkg::seg_ev_t   ev_o
);

  localparam int unsigned PosW = 48 + $clog2(MaxRuns);
  localparam int unsigned SrcW = fesm_pkg::SRC_W;

  // Stage A: products of the table read.
  logic        a_v_q, a_eot_q;
  logic [47:0] a_rb_q;
  logic [38:0] a_sp_q;
  // Stage B: overlap decision against the running position.
  logic        b_v_q, b_eot_q, b_tok_ok_q, b_ovl_q, b_done_q;
  logic [31:0] b_from_q, b_dst_q;
  logic [47:0] b_rb_q;
  logic [38:0] b_sp_q;
  // Stage C: finished segment.
  logic            c_v_q, c_eot_q, c_tok_ok_q, c_ovl_q, c_done_q;
  logic [SrcW-1:0] c_src_q;
  logic [31:0]     c_n_q, c_dst_q;

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] pos_next, off_w, end_w, diff_op, diff_po;
  logic            ovl, off_gt, done, tok_ok;
  logic [31:0]     from, dst;
  logic [47:0]     avail;
  logic [31:0]     rem, n;
  logic [39:0]     base;
  logic [SrcW-1:0] src;

  always_comb begin
    off_w    = PosW'(fork_offset_i);
    end_w    = PosW'({1'b0, fork_offset_i} + {1'b0, range_length_i});
    pos_next = pos_q + PosW'(a_rb_q);
    ovl      = (off_w < pos_next) && (end_w > pos_q);
    off_gt   = off_w > pos_q;
    diff_op  = off_w - pos_q;
    diff_po  = pos_q - off_w;
    from     = off_gt ? diff_op[31:0] : 32'd0;
    dst      = off_gt ? 32'd0 : diff_po[31:0];
    done     = pos_next >= end_w;
    tok_ok   = pos_q >= end_w;
    stop_o   = a_v_q && !a_eot_q && done;

    pos_d = pos_q;
    if (clear_i) begin
      pos_d = '0;
    end else if (a_v_q && !a_eot_q) begin
      pos_d = pos_next;
    end
  end

  always_comb begin
    avail = b_rb_q - 48'(b_from_q);
    rem   = range_length_i - b_dst_q;
    n     = (avail < 48'(rem)) ? avail[31:0] : rem;
    base  = 40'(start_sector_i) + 40'(b_sp_q);
    src   = SrcW'({base, {fesm_pkg::SECTOR_SHIFT{1'b0}}}) + SrcW'(b_from_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      pos_q <= '0;
    end else begin
      a_v_q <= rd_v_i && !stop_o && !ctl_i.kill;
      b_v_q <= a_v_q && !ctl_i.kill;
      c_v_q <= b_v_q && !ctl_i.kill;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_eot_q    <= rd_eot_i;
    a_rb_q     <= 48'(rd_data_i[15:0]) * 48'(block_bytes_i);
    a_sp_q     <= 39'(rd_data_i[31:16]) * 39'(block_bytes_i[31:fesm_pkg::SECTOR_SHIFT]);
    b_eot_q    <= a_eot_q;
    b_tok_ok_q <= tok_ok;
    b_ovl_q    <= ovl;
    b_done_q   <= done;
    b_from_q   <= from;
    b_dst_q    <= dst;
    b_rb_q     <= a_rb_q;
    b_sp_q     <= a_sp_q;
    c_eot_q    <= b_eot_q;
    c_tok_ok_q <= b_tok_ok_q;
    c_ovl_q    <= b_ovl_q;
    c_done_q   <= b_done_q;
    c_src_q    <= src;
    c_n_q      <= n;
    c_dst_q    <= b_dst_q;
  end

  always_comb begin
    ev_o.valid  = c_v_q;
    ev_o.eot    = c_eot_q;
    ev_o.tok_ok = c_tok_ok_q;
    ev_o.ovl    = c_ovl_q && !c_eot_q;
    ev_o.done   = c_done_q && !c_eot_q;
    ev_o.src    = c_src_q;
    ev_o.n      = c_n_q;
    ev_o.dst    = c_dst_q;
  end

endmodule

// ===== src/fesm_out_stage.sv =====
// Result stage: image bound check, one pending segment held until its last mark
// and final status are known, and the result register. Depends on fesm_pkg.
module fesm_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fesm_pkg::seg_ev_t   ev_i,
  input  logic [31:0]         image_bytes_i,
  input  logic                simple_v_i,
  input  fesm_pkg::status_e   simple_status_i,
  output fesm_pkg::walk_ctl_t ctl_o,
  output logic                res_valid_o,
  output fesm_pkg::res_t      res_o
);

  localparam int unsigned SrcW = fesm_pkg::SRC_W;

  logic                  pend_v_q, pend_v_d;
  logic                  pend_fin_q, pend_fin_d;
  fesm_pkg::status_e     pend_st_q, pend_st_d;
  logic [SrcW-1:0]       pend_src_q, pend_src_d;
  logic [31:0]           pend_n_q, pend_n_d;
  logic [31:0]           pend_dst_q, pend_dst_d;
  logic                  res_valid_q, emit;
  fesm_pkg::res_t        res_q, emit_res, pend_res;
  logic                  beyond, fin;
  fesm_pkg::status_e     tok_st;

  always_comb begin
    beyond = ev_i.ovl && ((51'(ev_i.src) + 51'(ev_i.n)) > 51'(image_bytes_i));
    tok_st = ev_i.tok_ok ? fesm_pkg::ST_OK : fesm_pkg::ST_UNCOVERED;

    pend_res.image_address = pend_src_q[47:0];
    pend_res.segment_bytes = pend_n_q;
    pend_res.dest_offset   = pend_dst_q;
    pend_res.status        = fesm_pkg::ST_OK;
    pend_res.last          = 1'b0;

    emit       = 1'b0;
    emit_res   = '0;
    fin        = 1'b0;
    pend_v_d   = pend_v_q;
    pend_fin_d = pend_fin_q;
    pend_st_d  = pend_st_q;
    pend_src_d = pend_src_q;
    pend_n_d   = pend_n_q;
    pend_dst_d = pend_dst_q;

    if (simple_v_i) begin
      emit            = 1'b1;
      emit_res.status = simple_status_i;
      emit_res.last   = 1'b1;
    end else if (ev_i.valid) begin
      if (ev_i.eot) begin
        // Table exhausted: close the walk on the held segment or alone.
        emit = 1'b1;
        fin  = 1'b1;
        if (pend_v_q) begin
          emit_res = pend_res;
        end
        emit_res.status = tok_st;
        emit_res.last   = 1'b1;
        pend_v_d        = 1'b0;
      end else if (ev_i.ovl) begin
        if (pend_v_q) begin
          emit     = 1'b1;
          emit_res = pend_res;
        end
        pend_v_d   = 1'b1;
        pend_fin_d = beyond || ev_i.done;
        pend_st_d  = beyond ? fesm_pkg::ST_BEYOND : fesm_pkg::ST_OK;
        pend_src_d = ev_i.src;
        pend_n_d   = ev_i.n;
        pend_dst_d = ev_i.dst;
      end else if (ev_i.done) begin
        emit = 1'b1;
        fin  = 1'b1;
        if (pend_v_q) begin
          emit_res = pend_res;
        end
        emit_res.status = fesm_pkg::ST_OK;
        emit_res.last   = 1'b1;
        pend_v_d        = 1'b0;
      end
    end else if (pend_v_q && pend_fin_q) begin
      emit            = 1'b1;
      fin             = 1'b1;
      emit_res        = pend_res;
      emit_res.status = pend_st_q;
      emit_res.last   = 1'b1;
      pend_v_d        = 1'b0;
    end

    ctl_o.kill   = ev_i.valid && beyond;
    ctl_o.finish = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q    <= 1'b0;
      pend_fin_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      pend_v_q    <= pend_v_d;
      pend_fin_q  <= pend_fin_d;
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_st_q  <= pend_st_d;
    pend_src_q <= pend_src_d;
    pend_n_q   <= pend_n_d;
    pend_dst_q <= pend_dst_d;
    if (emit) begin
      res_q <= emit_res;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/fork_extent_segment_mapper.sv =====
// Top level of the fork extent segment mapper: command decode, run count,
// table walk sequencing and configuration registers. Depends on fesm_pkg and submodules.
//
// Clear and append leave busy_o low, and their single status result appears on the
// next cycle. A translation raises busy_o and reads one table run per cycle from the
// run memory. The result that carries last passes through the read registers, the run
// memory, segment pipeline stages A, B and C and the result register, and is held once
// more in the pending segment when the final run walked gives a segment. The walk
// ends at the run that reaches the end of the range or gives a segment beyond the
// image, or at the end-of-table token when the table runs out. Segments leave at up
// to one per cycle, each valid for exactly one cycle on res_valid_o, and the receiver
// cannot hold them off; busy_o falls with the result that carries last.
module fork_extent_segment_mapper #(
  parameter int unsigned MaxRuns = fesm_pkg::MAX_RUNS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  fesm_pkg::req_t req_i,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i,
  output logic           res_valid_o,
  output fesm_pkg::res_t res_o
);

  localparam int unsigned IdxW = $clog2(MaxRuns);
  localparam int unsigned CntW = $clog2(MaxRuns + 1);

  logic [31:0]         block_bytes_q, image_bytes_q;
  logic [15:0]         start_sector_q;
  logic [CntW-1:0]     runs_q, runs_d, idx_q, idx_d;
  logic                busy_q, busy_d, issue_q, issue_d;
  logic                rd_v_q, rd_v_d, rd_eot_q, rd_eot_d;
  logic [31:0]         off_q, len_q;
  logic                acc, mem_we, simple_v, xl_go, stop;
  fesm_pkg::status_e   simple_st;
  logic [31:0]         rd_data;
  fesm_pkg::walk_ctl_t ctl;
  fesm_pkg::seg_ev_t   ev;

  assign acc         = start_i && !busy_q;
  assign busy_o      = busy_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    runs_d    = runs_q;
    simple_v  = 1'b0;
    simple_st = fesm_pkg::ST_OK;
    xl_go     = 1'b0;
    if (acc) begin
      unique case (req_i.opcode)
        fesm_pkg::OP_CLEAR: begin
          runs_d   = '0;
          simple_v = 1'b1;
        end
        fesm_pkg::OP_APPEND: begin
          simple_v = 1'b1;
          if (req_i.run_count != 16'd0) begin
            if (runs_q == CntW'(MaxRuns)) begin
              simple_st = fesm_pkg::ST_FULL;
            end else begin
              mem_we = 1'b1;
              runs_d = runs_q + CntW'(1);
            end
          end
        end
        fesm_pkg::OP_XLATE: begin
          xl_go = 1'b1;
        end
        default: begin
          simple_v = 1'b1;
        end
      endcase
    end
  end

  // Issue one table read per cycle; the read at index runs_q is the end-of-table token.
  always_comb begin
    rd_eot_d = (idx_q == runs_q);
    rd_v_d   = issue_q && !stop && !ctl.kill;
    issue_d  = issue_q;
    idx_d    = idx_q;
    busy_d   = busy_q;
    if (xl_go) begin
      issue_d = 1'b1;
      idx_d   = '0;
      busy_d  = 1'b1;
    end else begin
      if (stop || ctl.kill || (issue_q && rd_eot_d)) begin
        issue_d = 1'b0;
      end else if (issue_q) begin
        idx_d = idx_q + CntW'(1);
      end
      if (ctl.finish) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q  <= 32'd512;
      start_sector_q <= 16'd0;
      image_bytes_q  <= 32'd0;
      runs_q         <= '0;
      idx_q          <= '0;
      busy_q         <= 1'b0;
      issue_q        <= 1'b0;
      rd_v_q         <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          fesm_pkg::CFG_BLOCK_BYTES:  block_bytes_q  <= cfg_data_i;
          fesm_pkg::CFG_START_SECTOR: start_sector_q <= cfg_data_i[15:0];
          fesm_pkg::CFG_IMAGE_BYTES:  image_bytes_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
      runs_q  <= runs_d;
      idx_q   <= idx_d;
      busy_q  <= busy_d;
      issue_q <= issue_d;
      rd_v_q  <= rd_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_eot_q <= rd_eot_d;
    if (xl_go) begin
      off_q <= req_i.fork_offset;
      len_q <= req_i.range_length;
    end
  end

  fesm_run_mem #(
    .MaxRuns (MaxRuns)
  ) u_run_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (runs_q[IdxW-1:0]),
    .wdata_i ({req_i.run_start, req_i.run_count}),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (rd_data)
  );

  fesm_seg_pipe #(
    .MaxRuns (MaxRuns)
  ) u_seg_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .clear_i        (xl_go),
    .rd_v_i         (rd_v_q),
    .rd_eot_i       (rd_eot_q),
    .rd_data_i      (rd_data),
    .block_bytes_i  (block_bytes_q),
    .start_sector_i (start_sector_q),
    .fork_offset_i  (off_q),
    .range_length_i (len_q),
    .ctl_i          (ctl),
    .stop_o         (stop),
    .ev_o           (ev)
  );

  fesm_out_stage u_out_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ev_i            (ev),
    .image_bytes_i   (image_bytes_q),
    .simple_v_i      (simple_v),
    .simple_status_i (simple_st),
    .ctl_o           (ctl),
    .res_valid_o     (res_valid_o),
    .res_o           (res_o)
  );

  // An append with a nonzero run count to a full table reports the full status on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (req_i.opcode == fesm_pkg::OP_APPEND) && (req_i.run_count != 16'd0) &&
    (runs_q == CntW'(MaxRuns)) |=> res_valid_o && (res_o.status == fesm_pkg::ST_FULL))
    else $error("full table append did not report full status");

  // A translation ends exactly with the result that carries the last mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> res_valid_o && res_o.last)
    else $error("translation ended without a last result");

  // Results without the last mark only come from a translation in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy_q)
    else $error("non-final result outside a translation");

  // The end-of-table token is the final read of a walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q && rd_eot_q |=> !rd_v_q)
    else $error("table read issued after end-of-table token");

  // Run count never passes the table depth, and the table is not written during a walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (runs_q < CntW'(MaxRuns)) && !busy_q)
    else $error("run table written past its depth or during a walk");

endmodule
